// File: hw/rtl/ebr_pkg.sv
// Shared constants, types and codes of the event frame binning renderer.
`timescale 1ns / 1ps
`default_nettype none
package ebr_pkg;
    localparam int NUM_CAMERAS = 2;
    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int BANK_SIZE   = MAX_WIDTH * MAX_HEIGHT;
    localparam int MEM_DEPTH   = NUM_CAMERAS * 2 * BANK_SIZE;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int PIX_BITS    = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int AREA_BITS   = $clog2(BANK_SIZE + 1);
    localparam int WB          = $clog2(MAX_WIDTH + 1);
    localparam int HB          = $clog2(MAX_HEIGHT + 1);

    // epoch tag kept next to each pixel code
    localparam int TAG_BITS  = 8;
    localparam int WORD_BITS = TAG_BITS + 2;
    localparam logic [TAG_BITS-1:0] TAG_MAX = {TAG_BITS{1'b1}};

    localparam logic [1:0] CODE_NONE   = 2'd0;
    localparam logic [1:0] CODE_DARK   = 2'd1;
    localparam logic [1:0] CODE_BRIGHT = 2'd2;

    localparam logic [7:0] PIX_WHITE = 8'd255;

    // register indexes
    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_IDLE   = 3'd1;
    localparam logic [2:0] REG_ROTATE = 3'd2;
    localparam logic [2:0] REG_LIMIT  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    // effective configuration handed to the datapath
    typedef struct packed {
        logic [31:0]          period;
        logic [7:0]           idle;
        logic                 rotate;
        logic [9:0]           limit;
        logic [WB-1:0]        width;
        logic [HB-1:0]        height;
        logic [AREA_BITS-1:0] area;
    } t_cfg;
endpackage
`default_nettype wire

// File: hw/rtl/ebr_cfg.sv
// APB configuration registers with clamped effective values.
`timescale 1ns / 1ps
`default_nettype none
module ebr_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output ebr_pkg::t_cfg    o_cfg
);
    logic [31:0] r_period;
    logic [7:0]  r_idle;
    logic        r_rotate;
    logic [9:0]  r_limit;
    logic [9:0]  r_width;
    logic [8:0]  r_height;
    logic [2:0]  idx;
    logic [ebr_pkg::WB-1:0] w_eff;
    logic [ebr_pkg::HB-1:0] h_eff;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 32'd100000000;
            r_idle   <= 8'd127;
            r_rotate <= 1'b0;
            r_limit  <= 10'd30;
            r_width  <= 10'd640;
            r_height <= 9'd480;
        end else if (psel && penable && pwrite) begin
            case (idx)
                ebr_pkg::REG_PERIOD: r_period <= pwdata;
                ebr_pkg::REG_IDLE:   r_idle   <= pwdata[7:0];
                ebr_pkg::REG_ROTATE: r_rotate <= pwdata[0];
                ebr_pkg::REG_LIMIT:  r_limit  <= pwdata[9:0];
                ebr_pkg::REG_WIDTH:  r_width  <= pwdata[9:0];
                ebr_pkg::REG_HEIGHT: r_height <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            ebr_pkg::REG_PERIOD: prdata = r_period;
            ebr_pkg::REG_IDLE:   prdata = {24'd0, r_idle};
            ebr_pkg::REG_ROTATE: prdata = {31'd0, r_rotate};
            ebr_pkg::REG_LIMIT:  prdata = {22'd0, r_limit};
            ebr_pkg::REG_WIDTH:  prdata = {22'd0, r_width};
            ebr_pkg::REG_HEIGHT: prdata = {23'd0, r_height};
            default:             prdata = 32'd0;
        endcase
    end

    // clamp and substitute zero divisor / limit
    assign w_eff = (32'(r_width) > ebr_pkg::MAX_WIDTH) ?
                   ebr_pkg::WB'(ebr_pkg::MAX_WIDTH) : ebr_pkg::WB'(r_width);
    assign h_eff = (32'(r_height) > ebr_pkg::MAX_HEIGHT) ?
                   ebr_pkg::HB'(ebr_pkg::MAX_HEIGHT) : ebr_pkg::HB'(r_height);

    always_comb begin
        o_cfg.period = (r_period == 32'd0) ? 32'd1 : r_period;
        o_cfg.idle   = r_idle;
        o_cfg.rotate = r_rotate;
        o_cfg.limit  = (r_limit == 10'd0) ? 10'd1 : r_limit;
        o_cfg.width  = w_eff;
        o_cfg.height = h_eff;
        o_cfg.area   = ebr_pkg::AREA_BITS'(w_eff * h_eff);
    end
endmodule
`default_nettype wire

// File: hw/rtl/ebr_divider.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module ebr_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic      [63:0] o_quotient
);
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] trial;
    logic        fits;

    // one quotient bit per cycle
    assign trial = {r_rem, r_quo[63]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_div}) : trial[31:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// File: hw/rtl/ebr_pixel_mem.sv
// Pixel store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ebr_pixel_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [ebr_pkg::MEM_AW-1:0]    i_waddr,
    input  wire logic [ebr_pkg::WORD_BITS-1:0] i_wdata,
    input  wire logic [ebr_pkg::MEM_AW-1:0]    i_raddr,
    output logic      [ebr_pkg::WORD_BITS-1:0] o_rdata
);
    logic [ebr_pkg::WORD_BITS-1:0] mem [ebr_pkg::MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/event_to_frame_binning_renderer.sv
// Top level: event binning controller around the divider and the pixel store.
//
// Input words carry either an event (kind 0) or a pixel read (kind 1); each
// input word produces exactly one output word. Both channels use valid/ready.
// Configuration should be written over the APB port while the block is idle;
// the block itself does not enforce this. An in-frame event waits on the
// bit-serial divider that computes the time bin, then passes the origin, gap
// and decide steps and, when accepted, frame clearing and one pixel write;
// the next word can be taken once the result is valid.
// Events outside the frame skip the divider and go straight to the output
// step; a read word passes an address and a data step through the pixel
// store with its registered read port. Frames are cleared by bumping an 8-bit
// epoch tag per camera and bank; each 255th clear of a bank wipes that bank,
// one pixel a cycle. After reset the whole store is wiped with o_in_ready
// low; configuration writes are taken during that time.
// The result sits in an output register; a new word is accepted while it
// waits, and a stalled receiver holds the following result in the controller.
`timescale 1ns / 1ps
`default_nettype none
module event_to_frame_binning_renderer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic        i_camera,
    input  wire logic [63:0] i_event_stamp,
    input  wire logic [15:0] i_col,
    input  wire logic [15:0] i_row,
    input  wire logic        i_polarity,
    input  wire logic [18:0] i_read_address,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_accepted,
    output logic      [9:0]  o_closed_count,
    output logic      [63:0] o_closed_bin,
    output logic             o_gap_skipped,
    output logic      [7:0]  o_pixel_value
);
    typedef enum logic [11:0] {
        S_SWEEP  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_DIV    = 12'b000000000100,
        S_ORG    = 12'b000000001000,
        S_GAP    = 12'b000000010000,
        S_DECIDE = 12'b000000100000,
        S_CLR    = 12'b000001000000,
        S_WIPE   = 12'b000010000000,
        S_WRITE  = 12'b000100000000,
        S_RADDR  = 12'b001000000000,
        S_RDATA  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;

    localparam int AW = ebr_pkg::MEM_AW;
    localparam int PB = ebr_pkg::PIX_BITS;
    localparam int CN = ebr_pkg::NUM_CAMERAS;

    ebr_pkg::t_cfg cfg;
    t_state        r_state;

    // captured input word
    logic        r_kind, r_cam, r_pol;
    logic [15:0] r_col, r_row;
    logic [18:0] r_raddr_in;

    // per camera bin state
    logic        r_org_known [CN];
    logic [63:0] r_org_bin   [CN];
    logic        r_cur_known [CN];
    logic [63:0] r_cur_bin   [CN];
    logic        r_active    [CN];
    logic [ebr_pkg::TAG_BITS-1:0] r_epoch [CN*2];

    // working registers
    logic [63:0] r_sbin, r_rel, r_gap;
    logic        r_lt;
    logic [PB-1:0] r_pix;
    logic [1:0]  r_clr_mask;
    logic        r_wipe_bank;
    logic [PB-1:0] r_wipe_cnt;
    logic [AW-1:0] r_sweep_cnt;
    logic        r_rd_ok;

    // pending result
    logic        r_res_acc, r_res_skip;
    logic [9:0]  r_res_cnt;
    logic [63:0] r_res_bin;
    logic [7:0]  r_res_pix;

    // output register
    logic        r_out_valid;
    logic        r_o_acc, r_o_skip;
    logic [9:0]  r_o_cnt;
    logic [63:0] r_o_bin;
    logic [7:0]  r_o_pix;

    logic        in_fire, in_range, cam_ok_in, cam_ok;
    logic        div_start, div_done;
    logic [63:0] div_quo;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [ebr_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;
    logic [ebr_pkg::WB-1:0] ix;
    logic [ebr_pkg::HB-1:0] iy;
    logic [PB-1:0] n_pix;
    logic        act, clr_bank;
    logic [63:0] org_eff;
    logic [1:0]  act_idx, rd_idx, clr_idx;
    logic        gap_big;
    logic [1:0]  code;
    logic        rd_hit;

    ebr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the divider latches the timestamp at the accepting edge
    ebr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_event_stamp),
        .i_divisor  (cfg.period),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    ebr_pixel_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic logic [AW-1:0] bank_base(input logic cam, input logic bank);
        return AW'(AW'({cam, bank}) * AW'(ebr_pkg::BANK_SIZE));
    endfunction

    // input checks
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign cam_ok_in  = (32'(i_camera) < CN);
    assign cam_ok     = (32'(r_cam) < CN);
    assign in_range   = cam_ok_in && (32'(i_col) < 32'(cfg.width))
                        && (32'(i_row) < 32'(cfg.height));
    assign div_start  = in_fire && !i_kind && in_range;

    // pixel index of the captured event, mirrored when asked
    assign ix = cfg.rotate ? ebr_pkg::WB'(cfg.width - 1'b1 - ebr_pkg::WB'(r_col))
                           : ebr_pkg::WB'(r_col);
    assign iy = cfg.rotate ? ebr_pkg::HB'(cfg.height - 1'b1 - ebr_pkg::HB'(r_row))
                           : ebr_pkg::HB'(r_row);
    assign n_pix = PB'(iy * cfg.width + ix);

    assign act      = r_active[r_cam];
    assign act_idx  = {r_cam, act};
    assign rd_idx   = {r_cam, ~act};
    assign clr_bank = r_clr_mask[0] ? 1'b0 : 1'b1;
    assign clr_idx  = {r_cam, clr_bank};
    assign org_eff  = r_org_known[r_cam] ? r_org_bin[r_cam] : r_sbin;
    assign gap_big  = (|r_gap[63:10]) || (r_gap[9:0] > cfg.limit);
    assign code     = mem_rdata[1:0];
    assign rd_hit   = r_kind && r_rd_ok
                      && (mem_rdata[ebr_pkg::WORD_BITS-1:2] == r_epoch[rd_idx]);

    // memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep_cnt;
        mem_wdata = {{ebr_pkg::TAG_BITS{1'b0}}, ebr_pkg::CODE_NONE};
        case (r_state)
            S_SWEEP: mem_we = 1'b1;
            S_WIPE: begin
                mem_we    = 1'b1;
                mem_waddr = bank_base(r_cam, r_wipe_bank) + AW'(r_wipe_cnt);
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = bank_base(r_cam, act) + AW'(r_pix);
                mem_wdata = {r_epoch[act_idx],
                             r_pol ? ebr_pkg::CODE_BRIGHT : ebr_pkg::CODE_DARK};
            end
            default: ;
        endcase
    end
    // read address is presented in S_RADDR, data is checked in S_RDATA
    assign mem_raddr = bank_base(r_cam, ~act) + AW'(r_raddr_in[PB-1:0]);

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_cnt <= '0;
            r_clr_mask  <= 2'b00;
            for (int c = 0; c < CN; c++) begin
                r_org_known[c] <= 1'b0;
                r_org_bin[c]   <= 64'd0;
                r_cur_known[c] <= 1'b0;
                r_cur_bin[c]   <= 64'd0;
                r_active[c]    <= 1'b0;
            end
            for (int b = 0; b < CN*2; b++) begin
                r_epoch[b] <= ebr_pkg::TAG_BITS'(1);
            end
        end else begin
            case (r_state)
                S_SWEEP: begin
                    r_sweep_cnt <= r_sweep_cnt + AW'(1);
                    if (r_sweep_cnt == AW'(ebr_pkg::MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_kind)        r_state <= S_RADDR;
                        else if (in_range) r_state <= S_DIV;
                        else               r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) r_state <= S_ORG;
                end
                S_ORG: begin
                    r_org_known[r_cam] <= 1'b1;
                    r_org_bin[r_cam]   <= org_eff;
                    r_state <= (r_sbin < org_eff) ? S_OUT : S_GAP;
                end
                S_GAP: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (!r_cur_known[r_cam]) begin
                        r_cur_known[r_cam] <= 1'b1;
                        r_cur_bin[r_cam]   <= r_rel;
                        r_clr_mask         <= act ? 2'b10 : 2'b01;
                        r_state            <= S_CLR;
                    end else if (r_lt) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CLR;
                        if (r_gap != 64'd0) begin
                            r_active[r_cam]  <= ~act;
                            r_cur_bin[r_cam] <= r_rel;
                            if (!gap_big && r_gap[63:1] != 63'd0) r_clr_mask <= 2'b11;
                            else r_clr_mask <= act ? 2'b01 : 2'b10;
                        end
                    end
                end
                S_CLR: begin
                    if (r_clr_mask == 2'b00) begin
                        r_state <= S_WRITE;
                    end else if (r_epoch[clr_idx] == ebr_pkg::TAG_MAX) begin
                        r_wipe_bank <= clr_bank;
                        r_wipe_cnt  <= '0;
                        r_state     <= S_WIPE;
                    end else begin
                        r_epoch[clr_idx] <= r_epoch[clr_idx] + ebr_pkg::TAG_BITS'(1);
                        r_clr_mask[clr_bank] <= 1'b0;
                    end
                end
                S_WIPE: begin
                    r_wipe_cnt <= r_wipe_cnt + PB'(1);
                    if (r_wipe_cnt == PB'(ebr_pkg::BANK_SIZE - 1)) begin
                        r_epoch[{r_cam, r_wipe_bank}] <= ebr_pkg::TAG_BITS'(1);
                        r_clr_mask[r_wipe_bank]       <= 1'b0;
                        r_state <= S_CLR;
                    end
                end
                S_WRITE: r_state <= S_OUT;
                S_RADDR: r_state <= S_RDATA;
                S_RDATA: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= i_kind;
            r_cam      <= i_camera;
            r_col      <= i_col;
            r_row      <= i_row;
            r_pol      <= i_polarity;
            r_raddr_in <= i_read_address;
            r_res_acc  <= 1'b0;
            r_res_cnt  <= 10'd0;
            r_res_bin  <= 64'd0;
            r_res_skip <= 1'b0;
            r_res_pix  <= 8'd0;
        end
        case (r_state)
            S_DIV: begin
                r_pix <= n_pix;
                if (div_done) r_sbin <= div_quo;
            end
            S_ORG: r_rel <= r_sbin - org_eff;
            S_GAP: begin
                r_lt  <= r_rel < r_cur_bin[r_cam];
                r_gap <= r_rel - r_cur_bin[r_cam];
            end
            S_DECIDE: begin
                if (r_cur_known[r_cam] && !r_lt && r_gap != 64'd0) begin
                    r_res_bin  <= r_cur_bin[r_cam];
                    r_res_skip <= gap_big;
                    r_res_cnt  <= gap_big ? 10'd1 : r_gap[9:0];
                end
            end
            S_WRITE: r_res_acc <= 1'b1;
            S_RADDR: r_rd_ok <= cam_ok && (20'(r_raddr_in) < 20'(cfg.area));
            S_RDATA: begin
                if (rd_hit && code == ebr_pkg::CODE_DARK)        r_res_pix <= 8'd0;
                else if (rd_hit && code == ebr_pkg::CODE_BRIGHT) r_res_pix <= ebr_pkg::PIX_WHITE;
                else                                             r_res_pix <= cfg.idle;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_o_acc  <= r_res_acc;
            r_o_cnt  <= r_res_cnt;
            r_o_bin  <= r_res_bin;
            r_o_skip <= r_res_skip;
            r_o_pix  <= r_res_pix;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_o_acc;
    assign o_closed_count = r_o_cnt;
    assign o_closed_bin   = r_o_bin;
    assign o_gap_skipped  = r_o_skip;
    assign o_pixel_value  = r_o_pix;
endmodule
`default_nettype wire
